// ----- src/dual_ended_stack_unit_defines.svh -----
// Assertion macros for the dual-ended stack RTL.
// Needs clk and arst_n in the scope of each use; no other dependency.
`ifndef DUAL_ENDED_STACK_UNIT_DEFINES_SVH
`define DUAL_ENDED_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define DES_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define DES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/des_pkg.sv -----
// Shared types, widths and codes for the dual-ended stack.
// No dependencies; imported by des_core and dual_ended_stack_unit.
package des_pkg;

	localparam int DEPTH   = 256;
	localparam int AW      = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int FIDX_W  = 8;
	localparam int SIZE_W  = 9;
	localparam int ACT_W   = 4;
	localparam int STS_W   = 2;

	// capacity register and its clamp to the store depth
	localparam int CAP_W         = 9;
	localparam int CAP_RESET_INT = 256;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(CAP_RESET_INT);
	localparam logic [CNT_W-1:0] RI_RESET  =
		CNT_W'((CAP_RESET_INT > DEPTH) ? DEPTH : CAP_RESET_INT);

	// request codes
	localparam logic [ACT_W-1:0] ACT_FPUSH = 4'd0;
	localparam logic [ACT_W-1:0] ACT_FPOP  = 4'd1;
	localparam logic [ACT_W-1:0] ACT_FPEEK = 4'd2;
	localparam logic [ACT_W-1:0] ACT_RPUSH = 4'd3;
	localparam logic [ACT_W-1:0] ACT_RPOP  = 4'd4;
	localparam logic [ACT_W-1:0] ACT_RPEEK = 4'd5;
	localparam logic [ACT_W-1:0] ACT_FSRCH = 4'd6;
	localparam logic [ACT_W-1:0] ACT_RSRCH = 4'd7;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 4'd8;

	// status codes
	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;
	localparam logic [STS_W-1:0] STS_MISS  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [WORD_W-1:0] data;
		logic [FIDX_W-1:0] found_index;
		logic [SIZE_W-1:0] total_size;
		logic              empty_flag;
		logic              full_flag;
	} result_t;

	typedef struct packed {
		logic    vld;
		result_t res;
	} res_word_t;

endpackage

// ----- src/des_ram.sv -----
// Generic single-port RAM with a registered read.
// No dependencies; width and depth come from the instance.
module des_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one entry a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ----- src/des_core.sv -----
// Stack pointers, request sequencer and search walk over the word store.
// Depends on des_pkg, des_ram and dual_ended_stack_unit_defines.svh.
`include "dual_ended_stack_unit_defines.svh"

module des_core
	import des_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [WORD_W-1:0] value,
	input  logic [CNT_W-1:0]  cap,
	input  logic              out_free,
	output res_word_t         res_out
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  fc_q, fc_d;
	logic [CNT_W-1:0]  ri_q, ri_d;
	logic [AW-1:0]     ptr_q, ptr_d;
	logic              last_q, last_d;
	logic              front_q;
	logic [WORD_W-1:0] val_q;

	logic              in_acc;
	logic              ram_we;
	logic              ram_re;
	logic [AW-1:0]     ram_addr;
	logic [WORD_W-1:0] ram_rdata;

	logic              done;
	logic              go_read;
	logic              go_scan;
	logic              hit;
	logic [AW-1:0]     nptr;
	logic [CNT_W-1:0]  fc_m1;
	logic [CNT_W-1:0]  ri_m1;
	logic [CNT_W-1:0]  ri_p1;
	logic [CNT_W:0]    size_sum;
	result_t           res;

	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_acc   = in_valid && in_ready;
	assign fc_m1    = fc_q - CNT_W'(1);
	assign ri_m1    = ri_q - CNT_W'(1);
	assign ri_p1    = ri_q + CNT_W'(1);
	assign hit      = (ram_rdata == val_q);
	assign nptr     = front_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));

	des_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(value),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && go_read) begin
					state_d = ST_READ;
				end else if (in_acc && go_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (hit || last_q) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// pointer updates, store accesses and result fields
	always_comb begin
		fc_d       = fc_q;
		ri_d       = ri_q;
		ptr_d      = ptr_q;
		last_d     = last_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_addr   = ptr_q;
		go_read    = 1'b0;
		go_scan    = 1'b0;
		done       = 1'b0;
		res.status      = STS_OK;
		res.data        = '0;
		res.found_index = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					done = 1'b1;
					case (action)
						ACT_FPUSH: begin
							if (fc_q >= ri_q || fc_q >= cap) begin
								res.status = STS_FULL;
							end else begin
								ram_we   = 1'b1;
								ram_addr = fc_q[AW-1:0];
								fc_d     = fc_q + CNT_W'(1);
							end
						end
						ACT_FPOP, ACT_FPEEK: begin
							if (fc_q == '0) begin
								res.status = STS_EMPTY;
							end else begin
								ram_re   = 1'b1;
								ram_addr = fc_m1[AW-1:0];
								go_read  = 1'b1;
								done     = 1'b0;
								if (action == ACT_FPOP) begin
									fc_d = fc_m1;
								end
							end
						end
						ACT_RPUSH: begin
							if (ri_q <= fc_q || ri_q == '0) begin
								res.status = STS_FULL;
							end else begin
								ram_we   = 1'b1;
								ram_addr = ri_m1[AW-1:0];
								ri_d     = ri_m1;
							end
						end
						ACT_RPOP, ACT_RPEEK: begin
							if (ri_q >= cap) begin
								res.status = STS_EMPTY;
							end else begin
								ram_re   = 1'b1;
								ram_addr = ri_q[AW-1:0];
								go_read  = 1'b1;
								done     = 1'b0;
								if (action == ACT_RPOP) begin
									ri_d = ri_p1;
								end
							end
						end
						ACT_FSRCH: begin
							if (fc_q == '0) begin
								res.status = STS_MISS;
							end else begin
								ram_re   = 1'b1;
								ram_addr = fc_m1[AW-1:0];
								ptr_d    = fc_m1[AW-1:0];
								last_d   = (fc_m1 == '0);
								go_scan  = 1'b1;
								done     = 1'b0;
							end
						end
						ACT_RSRCH: begin
							if (ri_q >= cap) begin
								res.status = STS_MISS;
							end else begin
								ram_re   = 1'b1;
								ram_addr = ri_q[AW-1:0];
								ptr_d    = ri_q[AW-1:0];
								last_d   = (ri_p1 >= cap);
								go_scan  = 1'b1;
								done     = 1'b0;
							end
						end
						ACT_CLEAR: begin
							fc_d = '0;
							ri_d = cap;
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				done     = 1'b1;
				res.data = ram_rdata;
			end
			ST_SCAN: begin
				if (hit) begin
					done            = 1'b1;
					res.found_index = FIDX_W'(ptr_q);
				end else if (last_q) begin
					done       = 1'b1;
					res.status = STS_MISS;
				end else begin
					// compare the word read last cycle while fetching the next
					ram_re   = 1'b1;
					ram_addr = nptr;
					ptr_d    = nptr;
					last_d   = front_q ? (nptr == '0)
						: ((CNT_W'(nptr) + CNT_W'(1)) >= cap);
				end
			end
			default: begin
			end
		endcase

		// size and flags from the pointers as they stand after this request
		size_sum = {1'b0, fc_d};
		if (ri_d < cap) begin
			size_sum = size_sum + {1'b0, cap - ri_d};
		end
		res.total_size = size_sum[CNT_W] ? '1 : size_sum[SIZE_W-1:0];
		res.empty_flag = (fc_d == '0) && (ri_d >= cap);
		res.full_flag  = (fc_d >= ri_d);
	end

	assign res_out = {done, res};

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fc_q    <= '0;
			ri_q    <= RI_RESET;
		end else begin
			state_q <= state_d;
			fc_q    <= fc_d;
			ri_q    <= ri_d;
		end
	end

	// search context, held over the walk
	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		last_q <= last_d;
		if (in_acc) begin
			val_q   <= value;
			front_q <= (action == ACT_FSRCH);
		end
	end

	`DES_ASSERT_NOW(a_res_slot_free, done, out_free, "result word with output slot busy")
	`DES_ASSERT_NOW(a_write_on_accept, ram_we, in_acc, "store written outside an accepted push")
	`DES_ASSERT_NEXT(a_read_follows_accept, in_acc && go_read, state_q == ST_READ && !in_ready,
		"pop or peek did not hold off input for its read")
	`DES_ASSERT_NOW(a_front_bound, state_q != ST_READ, fc_q <= CNT_W'(DEPTH),
		"front count past store depth")
	`DES_ASSERT_NEXT(a_scan_ends, state_q == ST_SCAN && last_q, state_q == ST_IDLE,
		"search walked past its last entry")

endmodule

// ----- src/dual_ended_stack_unit.sv -----
// Top level of the dual-ended stack: capacity register, output word register, core.
// Depends on des_pkg, des_core and des_ram.
//
// channel   direction  handshake           payload
// s_*       in         s_tvalid/s_tready   tuser: action; tdata: value
// m_*       out        m_tvalid/m_tready   tuser: status; tdata: data .. full_flag
// cfg_*     in         cfg_valid/cfg_ready cfg_data: capacity
//
// Push, clear, unused codes and requests that fail on empty or full: result from ST_IDLE.
// Pop and peek: result from ST_READ, after the registered read of the word store.
// Search: ST_SCAN compares entries until a match or the stack end, one
//   store read a cycle through the single RAM port.
// Reset empties both stacks and sets capacity to 256; the store keeps its contents.
// Input is held off while a request is in flight or a result word is not taken.
module dual_ended_stack_unit
	import des_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic [3:0]  s_tuser,  // [3:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // [31:0] data, [39:32] found_index,
	                              // [48:40] total_size, [49] empty_flag,
	                              // [50] full_flag, [55:51] zero
	output logic [1:0]  m_tuser,  // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data  // [8:0] capacity
);

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] cap_eff;
	logic             out_vld_q;
	result_t          out_q;
	logic             out_free;
	res_word_t        core_res;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_vld_q || m_tready;

	// clamp capacity to the store depth
	assign cap_eff = (cap_q > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_q);

	des_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.action  (s_tuser),
		.value   (s_tdata),
		.cap     (cap_eff),
		.out_free(out_free),
		.res_out (core_res)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (core_res.vld) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_res.vld) begin
			out_q <= core_res.res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {5'b0, out_q.full_flag, out_q.empty_flag, out_q.total_size,
		out_q.found_index, out_q.data};

endmodule
